[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/bsws_pkg.sv]
package bsws_pkg;

  localparam int unsigned MaxWorkers = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned BoundW  = 16;
  localparam int unsigned ActiveW = 4;
  localparam int unsigned WidW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_STALL_BOUND  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UPDATE_LIMIT = 2'd2;

  localparam logic [BoundW-1:0]  RST_STALL_BOUND  = 16'd0;
  localparam logic [ActiveW-1:0] RST_ACTIVE_COUNT = 4'd8;
  localparam logic [CountW-1:0]  RST_UPDATE_LIMIT = 32'd1;

  typedef struct packed {
    logic cap_w;
    logic inc_rep;
    logic set_fin;
    logic idx_clr;
    logic idx_inc;
    logic scan_rd;
    logic scan_min;
    logic elig_clr;
    logic mask_build;
    logic load_rep;
    logic load_rel;
    logic load_term;
  } bsws_cmd_t;

  typedef struct packed {
    logic finished;
    logic inactive;
    logic limit_hit;
    logic scan_end;
    logic rep_elig;
    logic rel_any;
    logic rel_bit;
    logic rel_last;
    logic out_free;
  } bsws_stat_t;

endpackage

[sv/bounded_staleness_worker_scheduler_core.sv]
// Flow: a word from an inactive worker gives no result unless the run is finished; a terminating word
// gives its terminate result, and a scheduling word gives its results after two passes (minimum, then
// bound check) over the count memory's read port, then walks the indices to release, waiting out any
// output stall. A new word is accepted only in idle, after every result of the last word is loaded.
// Reset: asynchronous, active low; counts read as zero through per-entry valid bits, flags clear,
// registers return to their reset values, and the block is ready as soon as reset is released.
module bounded_staleness_worker_scheduler_core
  import bsws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WidW-1:0]    worker_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WidW-1:0]    grant_worker_o,
  output logic               terminate_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  bsws_cmd_t  cmd;
  bsws_stat_t stat;

  bsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsws_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .worker_id_i    (worker_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .grant_worker_o (grant_worker_o),
    .terminate_o    (terminate_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

[sv/bsws_ctrl.sv]
module bsws_ctrl
  import bsws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bsws_stat_t stat_i,
  output bsws_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_INC,
    S_MIN,
    S_ELIG,
    S_ELIGW,
    S_MASK,
    S_REP,
    S_REL,
    S_TERM
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_w = 1'b1;
          state_d     = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.finished) begin
          state_d = S_TERM;
        end else if (stat_i.inactive) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_INC;
        end
      end
      S_INC: begin
        cmd_o.inc_rep = 1'b1;
        if (stat_i.limit_hit) begin
          cmd_o.set_fin = 1'b1;
          state_d       = S_TERM;
        end else begin
          cmd_o.idx_clr  = 1'b1;
          cmd_o.elig_clr = 1'b1;
          state_d        = S_MIN;
        end
      end
      S_MIN: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.scan_min = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_ELIG;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_ELIG: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_ELIGW;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_ELIGW: begin
        state_d = S_MASK;
      end
      S_MASK: begin
        cmd_o.mask_build = 1'b1;
        cmd_o.idx_clr    = 1'b1;
        state_d          = S_REP;
      end
      S_REP: begin
        if (stat_i.rep_elig) begin
          if (stat_i.out_free) begin
            cmd_o.load_rep = 1'b1;
            state_d        = stat_i.rel_any ? S_REL : S_IDLE;
          end
        end else begin
          state_d = stat_i.rel_any ? S_REL : S_IDLE;
        end
      end
      S_REL: begin
        if (stat_i.rel_bit) begin
          if (stat_i.out_free) begin
            cmd_o.load_rel = 1'b1;
            if (stat_i.rel_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TERM: begin
        if (stat_i.out_free) begin
          cmd_o.load_term = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[sv/bsws_dpath.sv]
module bsws_dpath
  import bsws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [WidW-1:0]     worker_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WidW-1:0]     grant_worker_o,
  output logic                terminate_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  bsws_cmd_t           cmd_i,
  output bsws_stat_t          stat_o
);

  localparam int unsigned IW = (MaxWorkers > 1) ? $clog2(MaxWorkers) : 1;
  localparam int unsigned CW = $clog2(MaxWorkers + 1);

  logic [BoundW-1:0]  stall_bound_q;
  logic [ActiveW-1:0] active_cnt_q;
  logic [CountW-1:0]  update_limit_q;

  logic [CountW-1:0]  cnt_mem [MaxWorkers];
  logic [MaxWorkers-1:0] cnt_vld_q;
  logic [CountW-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_addr;
  logic [CountW-1:0]  cur_val;

  logic [WidW-1:0]    w_q;
  logic [IW-1:0]      w_idx;
  logic [MaxWorkers-1:0] w_oh;
  logic [CountW-1:0]  upd_cnt_q;
  logic [CountW-1:0]  upd_cnt_inc;
  logic               fin_q;

  logic [IW-1:0]      idx_q;
  logic [MaxWorkers-1:0] idx_oh;
  logic               scan_v_q;
  logic               scan_min_q;
  logic               scan_first_q;
  logic [IW-1:0]      scan_idx_q;
  logic [CountW-1:0]  min_q;
  logic [CountW-1:0]  lead;

  logic [MaxWorkers-1:0] elig_q;
  logic [MaxWorkers-1:0] halted_q;
  logic [MaxWorkers-1:0] rel_q;
  logic [MaxWorkers-1:0] rel_next;
  logic               rep_elig_q;

  logic [CW-1:0]      n_eff;
  logic               out_valid_q;
  logic [WidW-1:0]    grant_q;
  logic               term_q;
  logic               last_q;
  logic               out_free;
  logic               out_load;

  always_comb begin
    if (active_cnt_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(active_cnt_q) > 32'(MaxWorkers)) begin
      n_eff = CW'(MaxWorkers);
    end else begin
      n_eff = CW'(active_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_bound_q  <= RST_STALL_BOUND;
      active_cnt_q   <= RST_ACTIVE_COUNT;
      update_limit_q <= RST_UPDATE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALL_BOUND:  stall_bound_q  <= cfg_wdata_i[BoundW-1:0];
        CFG_ACTIVE_COUNT: active_cnt_q   <= cfg_wdata_i[ActiveW-1:0];
        CFG_UPDATE_LIMIT: update_limit_q <= cfg_wdata_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign w_idx       = IW'(w_q);
  assign w_oh        = {{(MaxWorkers-1){1'b0}}, 1'b1} << w_idx;
  assign idx_oh      = {{(MaxWorkers-1){1'b0}}, 1'b1} << idx_q;
  assign rd_addr     = cmd_i.scan_rd ? idx_q : w_idx;
  assign cur_val     = rd_vld_q ? rd_data_q : '0;
  assign upd_cnt_inc = upd_cnt_q + CountW'(1);
  assign lead        = cur_val - min_q;
  assign rel_next    = halted_q & elig_q & ~w_oh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc_rep) begin
      cnt_mem[w_idx] <= cur_val + CountW'(1);
    end
    rd_data_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.inc_rep) begin
        cnt_vld_q[w_idx] <= 1'b1;
      end
      rd_vld_q <= cnt_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_w) begin
      w_q <= worker_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_cnt_q    <= '0;
      fin_q        <= 1'b0;
      idx_q        <= '0;
      scan_v_q     <= 1'b0;
      scan_min_q   <= 1'b0;
      scan_first_q <= 1'b0;
      scan_idx_q   <= '0;
      min_q        <= '0;
      elig_q       <= '0;
      halted_q     <= '0;
      rel_q        <= '0;
      rep_elig_q   <= 1'b0;
    end else begin
      if (cmd_i.inc_rep) begin
        upd_cnt_q <= upd_cnt_inc;
      end
      if (cmd_i.set_fin) begin
        fin_q <= 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      scan_v_q     <= cmd_i.scan_rd;
      scan_min_q   <= cmd_i.scan_min;
      scan_first_q <= (idx_q == '0);
      scan_idx_q   <= idx_q;
      if (scan_v_q && scan_min_q) begin
        if (scan_first_q || (cur_val < min_q)) begin
          min_q <= cur_val;
        end
      end
      if (cmd_i.elig_clr) begin
        elig_q <= '0;
      end else if (scan_v_q && !scan_min_q) begin
        elig_q[scan_idx_q] <= (lead <= CountW'(stall_bound_q));
      end
      if (cmd_i.mask_build) begin
        rel_q      <= rel_next;
        rep_elig_q <= elig_q[w_idx];
        halted_q   <= (halted_q & ~rel_next & ~w_oh) | (elig_q[w_idx] ? '0 : w_oh);
      end else if (cmd_i.load_rel) begin
        rel_q <= rel_q & ~idx_oh;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.load_rep || cmd_i.load_rel || cmd_i.load_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rep) begin
      grant_q <= w_q;
      term_q  <= 1'b0;
      last_q  <= (rel_q == '0);
    end else if (cmd_i.load_rel) begin
      grant_q <= WidW'(idx_q);
      term_q  <= 1'b0;
      last_q  <= ((rel_q & ~idx_oh) == '0);
    end else if (cmd_i.load_term) begin
      grant_q <= '0;
      term_q  <= 1'b1;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grant_worker_o = grant_q;
  assign terminate_o    = term_q;
  assign last_o         = last_q;

  assign stat_o.finished  = fin_q;
  assign stat_o.inactive  = (32'(w_q) >= 32'(n_eff));
  assign stat_o.limit_hit = (upd_cnt_inc >= update_limit_q);
  assign stat_o.scan_end  = (CW'(idx_q) == (n_eff - CW'(1)));
  assign stat_o.rep_elig  = rep_elig_q;
  assign stat_o.rel_any   = (rel_q != '0);
  assign stat_o.rel_bit   = rel_q[idx_q];
  assign stat_o.rel_last  = ((rel_q & ~idx_oh) == '0);
  assign stat_o.out_free  = out_free;

endmodule

[sv/bsws_checker.sv]
`include "assert_macros.svh"

module bsws_checker
  import bsws_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [WidW-1:0] grant_worker_o,
  input logic            terminate_o,
  input logic            last_o
);

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  `ASSERT_SAME(a_term_word_shape, clk_i, rst_ni, out_valid_o && terminate_o,
               (grant_worker_o == '0) && last_o)

  `ASSERT_NEXT(a_term_sticky, clk_i, rst_ni,
               out_valid_o && out_ready_i && terminate_o && out_valid_o,
               !out_valid_o || terminate_o)

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(grant_worker_o) && $stable(terminate_o) && $stable(last_o))

endmodule

bind bounded_staleness_worker_scheduler_core bsws_checker u_checker (.*);

[tb/bounded_staleness_worker_scheduler_core_test.sv]
`timescale 1ns / 100ps

module bounded_staleness_worker_scheduler_core_test;
  import bsws_pkg::*;

  localparam int unsigned NumWorkers = MaxWorkers;
  localparam int unsigned SettleCycles = 48;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseWords = 30;

  typedef struct packed {
    logic [WidW-1:0] grant;
    logic            term;
    logic            last;
  } grant_word_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_RANDOM} row_kind_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TERM, EXP_SELF} row_check_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]  data;
    logic [WidW-1:0]  wid;
    row_check_e       check;
  } row_t;

  localparam int unsigned NumRows = 45;

  row_t rows [0:NumRows-1] = '{
    '{ROW_CFG,  CFG_UPDATE_LIMIT, 32'hFFFF_FFFF, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd1, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd3, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd4, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd5, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd6, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd7, EXP_MODEL},
    '{ROW_CFG,  CFG_STALL_BOUND, 32'h0000_FFFF, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd7, EXP_SELF},
    '{ROW_WORD, '0, '0, 3'd0, EXP_SELF},
    '{ROW_WORD, '0, '0, 3'd3, EXP_SELF},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd0, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd5, EXP_NONE},
    '{ROW_WORD, '0, '0, 3'd0, EXP_SELF},
    '{ROW_WORD, '0, '0, 3'd7, EXP_NONE},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd15, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd6, EXP_SELF},
    '{ROW_CFG,  CFG_STALL_BOUND, 32'd0, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd1, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd3, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_STALL_BOUND, 32'd1, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd1, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_STALL_BOUND, 32'd0, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_MODEL},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd2, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd1, EXP_MODEL},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd8, 3'd0, EXP_MODEL},
    '{ROW_RANDOM, '0, '0, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd8, 3'd0, EXP_MODEL},
    '{ROW_CFG,  CFG_UPDATE_LIMIT, 32'd0, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd3, EXP_TERM},
    '{ROW_WORD, '0, '0, 3'd0, EXP_TERM},
    '{ROW_WORD, '0, '0, 3'd7, EXP_TERM},
    '{ROW_CFG,  CFG_ACTIVE_COUNT, 32'd1, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd5, EXP_TERM},
    '{ROW_CFG,  CFG_UPDATE_LIMIT, 32'hFFFF_FFFF, 3'd0, EXP_MODEL},
    '{ROW_WORD, '0, '0, 3'd2, EXP_TERM}
  };

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [WidW-1:0]    worker_id_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [WidW-1:0]    grant_worker_o;
  logic               terminate_o;
  logic               last_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  logic [CountW-1:0]  worker_iters [NumWorkers];
  logic               worker_halted [NumWorkers];
  logic [CountW-1:0]  event_total;
  logic               run_over;
  logic [BoundW-1:0]  bound_cfg;
  logic [ActiveW-1:0] active_cfg;
  logic [CountW-1:0]  limit_cfg;

  grant_word_t        pending_grants [$];
  grant_word_t        step_grants [$];
  grant_word_t        want;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        gap_pct = 0;
  bit                 calm = 1'b0;
  bit                 long_hold_req = 1'b0;
  bit                 busy = 1'b0;

  bounded_staleness_worker_scheduler_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .worker_id_i   (worker_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .grant_worker_o(grant_worker_o),
    .terminate_o   (terminate_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk = ~clk;

  function automatic int unsigned live_workers();
    int unsigned n;
    n = 32'(active_cfg);
    if (n < 1) n = 1;
    if (n > NumWorkers) n = NumWorkers;
    return n;
  endfunction

  // Advances the scheduler state by one completion word and leaves its grants in step_grants.
  function automatic void schedule_word(input logic [WidW-1:0] wid);
    int unsigned n;
    logic [CountW-1:0] slowest;
    logic [CountW-1:0] lead;
    grant_word_t g;
    step_grants.delete();
    g.grant = '0;
    g.term = 1'b1;
    g.last = 1'b1;
    if (run_over) begin
      step_grants.push_back(g);
      return;
    end
    n = live_workers();
    if (wid >= n) return;
    worker_iters[wid] = worker_iters[wid] + CountW'(1);
    event_total = event_total + CountW'(1);
    if (event_total >= limit_cfg) begin
      run_over = 1'b1;
      step_grants.push_back(g);
      return;
    end
    slowest = worker_iters[0];
    for (int i = 1; i < n; i++) begin
      if (worker_iters[i] < slowest) slowest = worker_iters[i];
    end
    g.term = 1'b0;
    g.last = 1'b0;
    lead = worker_iters[wid] - slowest;
    if (lead > {{(CountW-BoundW){1'b0}}, bound_cfg}) begin
      worker_halted[wid] = 1'b1;
    end else begin
      worker_halted[wid] = 1'b0;
      g.grant = wid;
      step_grants.push_back(g);
    end
    for (int i = 0; i < n; i++) begin
      lead = worker_iters[i] - slowest;
      if (worker_halted[i] && lead <= {{(CountW-BoundW){1'b0}}, bound_cfg}) begin
        worker_halted[i] = 1'b0;
        g.grant = i[WidW-1:0];
        step_grants.push_back(g);
      end
    end
    if (step_grants.size() > 0) begin
      g = step_grants[step_grants.size()-1];
      g.last = 1'b1;
      step_grants[step_grants.size()-1] = g;
    end
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    busy = 1'b0;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    if (busy) settle();
    @(posedge clk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_STALL_BOUND:  bound_cfg = data[BoundW-1:0];
      CFG_ACTIVE_COUNT: active_cfg = data[ActiveW-1:0];
      CFG_UPDATE_LIMIT: limit_cfg = data[CountW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input logic [WidW-1:0] wid, input row_check_e check);
    grant_word_t g;
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    worker_id_i <= wid;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    schedule_word(wid);
    g.grant = '0;
    g.term = 1'b1;
    g.last = 1'b1;
    case (check)
      EXP_MODEL: foreach (step_grants[i]) pending_grants.push_back(step_grants[i]);
      EXP_TERM:  pending_grants.push_back(g);
      EXP_SELF: begin
        g.grant = wid;
        g.term = 1'b0;
        pending_grants.push_back(g);
      end
      default: ;
    endcase
    busy = 1'b1;
  endtask

  task automatic random_phases();
    int unsigned n;
    int unsigned sent;
    int unsigned pick;
    logic [WidW-1:0] fav;
    logic [WidW-1:0] wid;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case ($urandom_range(0, 5))
        0: cfg_write(CFG_STALL_BOUND, 32'd0);
        1: cfg_write(CFG_STALL_BOUND, 32'd1);
        2: cfg_write(CFG_STALL_BOUND, 32'd2);
        3: cfg_write(CFG_STALL_BOUND, $urandom_range(3, 6));
        4: cfg_write(CFG_STALL_BOUND, 32'h0000_FFFF);
        default: cfg_write(CFG_STALL_BOUND, $urandom);
      endcase
      if ($urandom_range(0, 9) < 7) cfg_write(CFG_ACTIVE_COUNT, $urandom_range(2, 8));
      else cfg_write(CFG_ACTIVE_COUNT, $urandom_range(0, 15));
      if ($urandom_range(0, 1) != 0) cfg_write(CFG_UPDATE_LIMIT, 32'hFFFF_FFFF);
      else cfg_write(CFG_UPDATE_LIMIT, $urandom | 32'h0000_1000);
      if (ph == PhaseCount - 1) calm = 1'b1;
      if (ph == 3) long_hold_req = 1'b1;
      gap_pct = (ph % 3 == 0) ? 0 : 30;
      n = live_workers();
      fav = WidW'($urandom_range(0, n - 1));
      sent = 0;
      while (sent < PhaseWords) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) wid = WidW'($urandom_range(0, NumWorkers - 1));
        else if (pick < 40) wid = fav;
        else wid = WidW'($urandom_range(0, n - 1));
        send_word(wid, EXP_MODEL);
        if (wid < n) sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NumWorkers; i++) begin
      worker_iters[i] = '0;
      worker_halted[i] = 1'b0;
    end
    event_total = '0;
    run_over = 1'b0;
    bound_cfg = RST_STALL_BOUND;
    active_cfg = RST_ACTIVE_COUNT;
    limit_cfg = RST_UPDATE_LIMIT;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    for (int r = 0; r < NumRows; r++) begin
      case (rows[r].kind)
        ROW_CFG:    cfg_write(rows[r].idx, rows[r].data);
        ROW_WORD:   send_word(rows[r].wid, rows[r].check);
        ROW_RANDOM: random_phases();
        default: ;
      endcase
    end
    settle();
    if (error_count == 0) begin
      $display("** bounded_staleness_worker_scheduler_core: PASSED **");
    end else begin
      $display("** bounded_staleness_worker_scheduler_core: FAILED **");
    end
    $finish;
  end

  initial begin
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: expected no word, actual grant_worker %0d terminate %0d last %0d",
                 $time, grant_worker_o, terminate_o, last_o);
        error_count++;
      end else begin
        want = pending_grants.pop_front();
        if (grant_worker_o !== want.grant) begin
          $display("%0t: grant_worker expected %0d, actual %0d",
                   $time, want.grant, grant_worker_o);
          error_count++;
        end
        if (terminate_o !== want.term) begin
          $display("%0t: terminate expected %0d, actual %0d", $time, want.term, terminate_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0d, actual %0d", $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_grants.size());
      $display("** bounded_staleness_worker_scheduler_core: FAILED **");
      $finish;
    end
  end

endmodule

[files.f]
+incdir+sv
sv/bsws_pkg.sv
sv/bsws_ctrl.sv
sv/bsws_dpath.sv
sv/bounded_staleness_worker_scheduler_core.sv
sv/bsws_checker.sv
tb/bounded_staleness_worker_scheduler_core_test.sv
